// ===== rtl/ffgra_pkg.sv =====
`default_nettype none
package ffgra_pkg;

    localparam int MAX_COLUMNS = 16;
    localparam int MAX_ROWS    = 16;
    localparam int ID_BITS     = 8;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SIZE_W = 5;
    localparam int ROW_BITS = MAX_COLUMNS * ID_BITS;

    // actions
    localparam logic [1:0] ACT_PLACE  = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_MOVED   = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;
    localparam logic [2:0] ST_RANGE   = 3'd6;

    // register indexes
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef struct packed {
        logic       load;
        logic       rd_y;
        logic       take_owner;
        logic       scan;
        logic       fill_start;
        logic       fill;
        logic       rm_start;
        logic       rm_clr;
        logic       res_en;
        logic [2:0] res_code;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] act;
        logic       bad_place;
        logic       out_range;
        logic       owner_zero;
        logic       scan_last;
        logic       req_ok;
        logic       ff_found;
        logic       fill_last;
        logic       rm_last;
    } t_sts;

    // clamp a size register to 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] mx);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) r = SIZE_W'(1);
        if (v > mx) r = mx;
        return r;
    endfunction

    // columns start .. start+w-1 set
    function automatic logic [MAX_COLUMNS-1:0] lane_mask(input logic [COL_W-1:0] start,
                                                         input logic [SIZE_W-1:0] w);
        logic [2*MAX_COLUMNS+31:0] m;
        m = (((2*MAX_COLUMNS+32)'(1)) << w) - (2*MAX_COLUMNS+32)'(1);
        m = m << start;
        return m[MAX_COLUMNS-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ffgra_ctrl.sv =====
`default_nettype none
module ffgra_ctrl
    import ffgra_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_OWN   = 4'd2;
    localparam logic [3:0] S_RMRD  = 4'd3;
    localparam logic [3:0] S_RMCLR = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_PICK  = 4'd6;
    localparam logic [3:0] S_FILL  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_ovld, n_ovld;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

    always_comb begin
        n_state = r_state;
        n_ovld  = r_ovld && !i_out_ready;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.rd_y = 1'b1;
                if (i_sts.act == ACT_PLACE) begin
                    if (i_sts.bad_place) begin
                        o_cmd.res_en   = 1'b1;
                        o_cmd.res_code = ST_RANGE;
                        n_state        = S_FIN;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else if (i_sts.act == ACT_REMOVE || i_sts.act == ACT_READ) begin
                    if (i_sts.out_range) begin
                        o_cmd.res_en   = 1'b1;
                        o_cmd.res_code = ST_RANGE;
                        n_state        = S_FIN;
                    end else begin
                        n_state = S_OWN;
                    end
                end else begin
                    o_cmd.res_en   = 1'b1;
                    o_cmd.res_code = ST_RANGE;
                    n_state        = S_FIN;
                end
            end
            S_OWN: begin
                o_cmd.take_owner = 1'b1;
                o_cmd.res_en     = 1'b1;
                if (i_sts.act == ACT_READ) begin
                    o_cmd.res_code = ST_READ;
                    n_state        = S_FIN;
                end else if (i_sts.owner_zero) begin
                    o_cmd.res_code = ST_EMPTY;
                    n_state        = S_FIN;
                end else begin
                    o_cmd.res_code = ST_REMOVED;
                    o_cmd.rm_start = 1'b1;
                    n_state        = S_RMRD;
                end
            end
            S_RMRD: begin
                n_state = S_RMCLR;
            end
            S_RMCLR: begin
                o_cmd.rm_clr = 1'b1;
                n_state      = i_sts.rm_last ? S_FIN : S_RMRD;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.res_en = 1'b1;
                if (i_sts.req_ok || i_sts.ff_found) begin
                    o_cmd.res_code   = i_sts.req_ok ? ST_PLACED : ST_MOVED;
                    o_cmd.fill_start = 1'b1;
                    n_state          = S_FILL;
                end else begin
                    o_cmd.res_code = ST_NOSPACE;
                    n_state        = S_FIN;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovld || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_ovld     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ffgra_dp.sv =====
`default_nettype none
module ffgra_dp
    import ffgra_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [1:0]        i_action,
    input  wire logic [7:0]        i_owner_id,
    input  wire logic [4:0]        i_rect_width,
    input  wire logic [4:0]        i_rect_height,
    input  wire logic [3:0]        i_pos_x,
    input  wire logic [3:0]        i_pos_y,
    input  wire logic [SIZE_W-1:0] i_grid_columns,
    input  wire logic [SIZE_W-1:0] i_grid_rows,
    output logic [2:0]             o_status,
    output logic [3:0]             o_placed_x,
    output logic [3:0]             o_placed_y,
    output logic [7:0]             o_cell_owner
);

    // item fields
    logic [1:0]         r_act;
    logic [ID_BITS-1:0] r_id;
    logic [SIZE_W-1:0]  r_w, r_h;
    logic [COL_W-1:0]   r_x;
    logic [ROW_W-1:0]   r_y;
    logic [SIZE_W-1:0]  r_cols, r_rows;

    // walk state
    logic [ROW_W-1:0]   r_row;
    logic [SIZE_W-1:0]  r_vcnt [MAX_COLUMNS];
    logic [SIZE_W-1:0]  n_vcnt [MAX_COLUMNS];
    logic               r_found, r_req;
    logic [COL_W-1:0]   r_ffx, r_px;
    logic [ROW_W-1:0]   r_ffy, r_py;
    logic [ID_BITS-1:0] r_owner;
    logic [2:0]         r_status;

    // occupancy bits in flops, ids in a row-wide memory
    logic [MAX_COLUMNS-1:0] r_occ [MAX_ROWS];
    logic [ROW_BITS-1:0]    r_mem [MAX_ROWS];
    logic [ROW_BITS-1:0]    r_rd;
    logic [ROW_W-1:0]       rd_addr;

    logic [MAX_COLUMNS-1:0] col_ok, win_ok, fmask, col_act, match;
    logic [COL_W-1:0]       first_col;
    logic [ID_BITS-1:0]     cell_id;
    logic                   cell_used;
    logic [ID_BITS-1:0]     cell_owner;
    logic [5:0]             row_end, req_end, fill_end;

    assign rd_addr = i_cmd.rd_y ? r_y : r_row;

    always_comb begin
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            if (r_occ[r_row][i])
                n_vcnt[i] = '0;
            else if (r_vcnt[i] == SIZE_W'(MAX_ROWS))
                n_vcnt[i] = r_vcnt[i];
            else
                n_vcnt[i] = r_vcnt[i] + SIZE_W'(1);
            col_ok[i]  = (n_vcnt[i] >= r_h);
            col_act[i] = (SIZE_W'(i) < r_cols);
            match[i]   = r_occ[r_row][i] && col_act[i]
                         && (r_rd[i*ID_BITS +: ID_BITS] == r_owner);
        end
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            win_ok[i] = ((~col_ok & lane_mask(COL_W'(i), r_w)) == '0)
                        && ((6'(i) + 6'(r_w)) <= 6'(r_cols));
        end
        first_col = '0;
        for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
            if (win_ok[i]) first_col = COL_W'(i);
        end
    end

    assign fmask      = lane_mask(r_px, r_w);
    assign cell_id    = r_rd[r_x*ID_BITS +: ID_BITS];
    assign cell_used  = r_occ[r_y][r_x];
    assign cell_owner = cell_used ? cell_id : '0;
    assign row_end    = 6'(r_row) + 6'd1;
    assign req_end    = 6'(r_y) + 6'(r_h);
    assign fill_end   = 6'(r_py) + 6'(r_h);

    assign o_sts.act        = r_act;
    assign o_sts.bad_place  = (r_id == '0) || (r_w == '0) || (r_h == '0);
    assign o_sts.out_range  = (SIZE_W'(r_x) >= r_cols) || (SIZE_W'(r_y) >= r_rows);
    assign o_sts.owner_zero = (cell_owner == '0);
    assign o_sts.scan_last  = (row_end == 6'(r_rows));
    assign o_sts.rm_last    = (row_end == 6'(r_rows));
    assign o_sts.req_ok     = r_req;
    assign o_sts.ff_found   = r_found;
    assign o_sts.fill_last  = (row_end == fill_end);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_id    <= i_owner_id[ID_BITS-1:0];
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_x     <= i_pos_x[COL_W-1:0];
            r_y     <= i_pos_y[ROW_W-1:0];
            r_cols  <= clamp_size(i_grid_columns, SIZE_W'(MAX_COLUMNS));
            r_rows  <= clamp_size(i_grid_rows, SIZE_W'(MAX_ROWS));
            r_row   <= '0;
            r_found <= 1'b0;
            r_req   <= 1'b0;
            r_px    <= '0;
            r_py    <= '0;
            r_owner <= '0;
            for (int i = 0; i < MAX_COLUMNS; i++) r_vcnt[i] <= '0;
        end
        if (i_cmd.take_owner) r_owner <= cell_owner;
        if (i_cmd.scan) begin
            for (int i = 0; i < MAX_COLUMNS; i++) r_vcnt[i] <= n_vcnt[i];
            r_row <= r_row + ROW_W'(1);
            if (!r_found && (win_ok != '0)) begin
                r_found <= 1'b1;
                r_ffx   <= first_col;
                r_ffy   <= ROW_W'(row_end - 6'(r_h));
            end
            if (row_end == req_end && win_ok[r_x]) r_req <= 1'b1;
        end
        if (i_cmd.fill_start) begin
            r_row <= r_req ? r_y : r_ffy;
            r_px  <= r_req ? r_x : r_ffx;
            r_py  <= r_req ? r_y : r_ffy;
        end
        if (i_cmd.rm_start) r_row <= '0;
        if (i_cmd.fill || i_cmd.rm_clr) r_row <= r_row + ROW_W'(1);
        if (i_cmd.res_en) r_status <= i_cmd.res_code;
        if (i_cmd.emit) begin
            o_status     <= r_status;
            o_placed_x   <= 4'(r_px);
            o_placed_y   <= 4'(r_py);
            o_cell_owner <= 8'(r_owner);
        end
    end

    // occupancy flops, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < MAX_ROWS; r++) r_occ[r] <= '0;
        end else begin
            if (i_cmd.fill) r_occ[r_row] <= r_occ[r_row] | fmask;
            if (i_cmd.rm_clr) r_occ[r_row] <= r_occ[r_row] & ~match;
        end
    end

    // id memory, lane write enables, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            for (int i = 0; i < MAX_COLUMNS; i++) begin
                if (fmask[i]) r_mem[r_row][i*ID_BITS +: ID_BITS] <= r_id;
            end
        end
        r_rd <= r_mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/first_fit_grid_region_allocator.sv =====
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser action, tdata request
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata result
// cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_addr, i_cfg_data
//
// one item at a time; read, bad request or empty remove make no row pass,
// remove reads then clears each row, place scans each row and fills rect_height
// rows when a fit is found (the row-serial fit scan and one id-memory row per fill)
// occupancy lives in flops cleared by reset, so no clearing pass is needed
// a finished result sits in the output register while the next item is taken
// configuration is always ready and is sampled when an item is accepted
`default_nettype none
module first_fit_grid_region_allocator
    import ffgra_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // owner_id[7:0], rect_width[12:8], rect_height[17:13], pos_x[21:18], pos_y[25:22]
    input  wire logic [31:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // placed_x[3:0], placed_y[7:4], cell_owner[15:8]
    output logic [15:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]       m_axis_tuser,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_addr,
    input  wire logic [4:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // size registers
    logic [SIZE_W-1:0] r_grid_columns, r_grid_rows;

    logic [3:0] placed_x, placed_y;
    logic [7:0] cell_owner;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= SIZE_W'(16);
            r_grid_rows    <= SIZE_W'(16);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_COLS: r_grid_columns <= i_cfg_data;
                CFG_ROWS: r_grid_rows    <= i_cfg_data;
                default:  r_grid_rows    <= r_grid_rows;
            endcase
        end
    end

    // sequencer
    ffgra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // grid store, fit scan and result registers
    ffgra_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (s_axis_tuser),
        .i_owner_id     (s_axis_tdata[7:0]),
        .i_rect_width   (s_axis_tdata[12:8]),
        .i_rect_height  (s_axis_tdata[17:13]),
        .i_pos_x        (s_axis_tdata[21:18]),
        .i_pos_y        (s_axis_tdata[25:22]),
        .i_grid_columns (r_grid_columns),
        .i_grid_rows    (r_grid_rows),
        .o_status       (m_axis_tuser),
        .o_placed_x     (placed_x),
        .o_placed_y     (placed_y),
        .o_cell_owner   (cell_owner)
    );

    assign m_axis_tdata = {cell_owner, placed_y, placed_x};

endmodule
`default_nettype wire
